// File: design/bem_pkg.sv
// ----------------------------------------------------------------------------
// bem_pkg
// Shared constants and controller/datapath interface types for the byte
// entropy meter.
// ----------------------------------------------------------------------------
`default_nettype none

package bem_pkg;

  localparam int BIN_COUNT   = 256;
  localparam int COUNT_WIDTH = 24;
  localparam int FRAC_BITS   = 12;

  localparam int BIN_W   = $clog2(BIN_COUNT);
  localparam int EXP_W   = $clog2(COUNT_WIDTH);
  localparam int LOG_W   = EXP_W + FRAC_BITS;
  localparam int PROD_W  = COUNT_WIDTH + LOG_W;
  localparam int ACC_W   = PROD_W + BIN_W;
  localparam int DCNT_W  = $clog2(ACC_W);
  localparam int ITER_W  = $clog2(FRAC_BITS + 1);
  localparam int MANT_W  = 31;            // Q1.30 mantissa
  localparam int SQ_W    = 2 * MANT_W;

  localparam int ENT_W   = 16;
  localparam int RUN_W   = 24;
  localparam logic [LOG_W-1:0] ENTROPY_MAX = LOG_W'(32768);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // configuration register map
  localparam int           ADDR_W        = 3;
  localparam logic         REG_THRESHOLD = 1'b0;
  localparam logic [15:0]  THRESH_RESET  = 16'd28672;

  typedef struct packed {
    logic take;        // input beat accepted
    logic rd_byte;     // read bin of the captured byte
    logic wr_inc;      // write back incremented bin, bump total
    logic rd_walk;     // read bin at walk pointer
    logic wr_zero;     // clear bin at walk pointer
    logic addr_inc;    // advance walk pointer
    logic log_start;   // start log2 unit
    logic log_src_n;   // log2 operand: byte total instead of bin
    logic prod_load;   // f * log2(f)
    logic acc_add;     // accumulate product
    logic div_start;   // latch log2(N), start sum / N
    logic res_load;    // form result, clear run state
  } ctl_cmd_t;

  typedef struct packed {
    logic last_flag;
    logic bin_zero;
    logic addr_last;
    logic log_done;
    logic div_done;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

// File: design/bem_log2.sv
// ----------------------------------------------------------------------------
// bem_log2
// Iterative truncating log2: shift-normalize one bit per cycle, then one
// mantissa squaring per fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module bem_log2
  import bem_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [COUNT_WIDTH-1:0] operand,
  output logic                        done,
  output logic [LOG_W-1:0]            result
);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_SQ   = 2'd2;

  logic [1:0]             lst_r, lst_nxt;
  logic [COUNT_WIDTH-1:0] v_r, v_nxt;
  logic [EXP_W-1:0]       s_r, s_nxt;
  logic [MANT_W-1:0]      m_r, m_nxt;
  logic [LOG_W-1:0]       r_r, r_nxt;
  logic [ITER_W-1:0]      it_r, it_nxt;
  logic                   done_r, done_nxt;
  logic [SQ_W-1:0]        sq;
  logic [MANT_W:0]        sqs;

  assign sq  = SQ_W'(m_r) * SQ_W'(m_r);
  assign sqs = sq[MANT_W-1 +: MANT_W+1];

  always_comb begin
    lst_nxt  = lst_r;
    v_nxt    = v_r;
    s_nxt    = s_r;
    m_nxt    = m_r;
    r_nxt    = r_r;
    it_nxt   = it_r;
    done_nxt = 1'b0;
    unique case (lst_r)
      L_IDLE: begin
        if (start) begin
          v_nxt   = operand;
          s_nxt   = '0;
          lst_nxt = L_NORM;
        end
      end
      L_NORM: begin
        if (v_r[COUNT_WIDTH-1]) begin
          m_nxt   = {v_r, {(MANT_W-COUNT_WIDTH){1'b0}}};
          r_nxt   = LOG_W'(EXP_W'(COUNT_WIDTH - 1) - s_r);
          it_nxt  = '0;
          lst_nxt = L_SQ;
        end else begin
          v_nxt = {v_r[COUNT_WIDTH-2:0], 1'b0};
          s_nxt = s_r + 1'b1;
        end
      end
      L_SQ: begin
        // square >= 2.0 gives a one bit and halves the mantissa
        if (sqs[MANT_W]) begin
          m_nxt = sqs[MANT_W:1];
        end else begin
          m_nxt = sqs[MANT_W-1:0];
        end
        r_nxt  = {r_r[LOG_W-2:0], sqs[MANT_W]};
        it_nxt = it_r + 1'b1;
        if (it_r == ITER_W'(FRAC_BITS - 1)) begin
          done_nxt = 1'b1;
          lst_nxt  = L_IDLE;
        end
      end
      default: lst_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lst_r  <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      lst_r  <= lst_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r  <= v_nxt;
    s_r  <= s_nxt;
    m_r  <= m_nxt;
    r_r  <= r_nxt;
    it_r <= it_nxt;
  end

  assign done   = done_r;
  assign result = r_r;

endmodule

`default_nettype wire

// File: design/bem_datapath.sv
// ----------------------------------------------------------------------------
// bem_datapath
// Histogram memory, byte total, product/accumulate, restoring divider and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bem_datapath
  import bem_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire ctl_cmd_t               cmd,
  output ctl_sts_t                    sts,
  input  wire logic [7:0]             in_data_byte,
  input  wire logic                   in_last_byte,
  input  wire logic [15:0]            threshold,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [ENT_W-1:0]            out_entropy_value,
  output logic                        out_is_high,
  output logic [RUN_W-1:0]            out_run_length
);

  logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic [BIN_W-1:0]       byte_r;
  logic                   last_r;
  logic [BIN_W-1:0]       addr_r;
  logic [COUNT_WIDTH-1:0] total_r;
  logic [ACC_W-1:0]       acc_r;
  logic [PROD_W-1:0]      prod_r;
  logic [LOG_W-1:0]       lnn_r;
  logic [COUNT_WIDTH-1:0] rem_r;
  logic [ACC_W-1:0]       quo_r;
  logic [DCNT_W-1:0]      dcnt_r;
  logic                   dbusy_r;
  logic                   ddone_r;
  logic                   ov_r;
  logic [ENT_W-1:0]       ent_r;
  logic                   high_r;
  logic [RUN_W-1:0]       run_r;

  logic                   mem_we;
  logic [BIN_W-1:0]       wr_addr;
  logic [BIN_W-1:0]       rd_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [COUNT_WIDTH-1:0] bin_inc;
  logic [COUNT_WIDTH:0]   dtrial;
  logic                   dfit;
  logic [LOG_W-1:0]       log_res;
  logic                   log_done;
  logic [COUNT_WIDTH-1:0] log_op;
  logic [LOG_W-1:0]       h_raw;
  logic [LOG_W-1:0]       h_clip;

  bem_log2 u_log2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.log_start),
    .operand (log_op),
    .done    (log_done),
    .result  (log_res)
  );

  assign log_op  = cmd.log_src_n ? total_r : rd_data_r;
  assign bin_inc = (rd_data_r == COUNT_MAX) ? rd_data_r : rd_data_r + 1'b1;
  assign mem_we  = cmd.wr_inc | cmd.wr_zero;
  assign wr_addr = cmd.wr_inc ? byte_r : addr_r;
  assign wr_data = cmd.wr_inc ? bin_inc : '0;
  assign rd_addr = cmd.rd_byte ? byte_r : addr_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_byte | cmd.rd_walk) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // restoring divider step
  assign dtrial = {rem_r, quo_r[ACC_W-1]};
  assign dfit   = dtrial >= {1'b0, total_r};

  assign h_raw  = ({{(ACC_W-LOG_W){1'b0}}, lnn_r} > quo_r) ? lnn_r - quo_r[LOG_W-1:0] : '0;
  assign h_clip = (h_raw > ENTROPY_MAX) ? ENTROPY_MAX : h_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      total_r <= '0;
      acc_r   <= '0;
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      ddone_r <= 1'b0;
      if (cmd.addr_inc) begin
        addr_r <= addr_r + 1'b1;
      end
      if (cmd.wr_inc && total_r != COUNT_MAX) begin
        total_r <= total_r + 1'b1;
      end
      if (cmd.acc_add) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      if (cmd.div_start) begin
        dbusy_r <= 1'b1;
      end else if (dbusy_r && dcnt_r == DCNT_W'(ACC_W - 1)) begin
        dbusy_r <= 1'b0;
        ddone_r <= 1'b1;
      end
      if (cmd.res_load) begin
        total_r <= '0;
        acc_r   <= '0;
        ov_r    <= 1'b1;
      end else if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
    if (cmd.prod_load) begin
      prod_r <= PROD_W'(rd_data_r) * PROD_W'(log_res);
    end
    if (cmd.div_start) begin
      lnn_r  <= log_res;
      rem_r  <= '0;
      quo_r  <= acc_r;
      dcnt_r <= '0;
    end else if (dbusy_r) begin
      rem_r  <= dfit ? COUNT_WIDTH'(dtrial - {1'b0, total_r}) : dtrial[COUNT_WIDTH-1:0];
      quo_r  <= {quo_r[ACC_W-2:0], dfit};
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.res_load) begin
      ent_r  <= h_clip[ENT_W-1:0];
      high_r <= h_clip >= LOG_W'(threshold);
      run_r  <= RUN_W'(total_r);
    end
  end

  always_comb begin
    sts.last_flag = last_r;
    sts.bin_zero  = rd_data_r == '0;
    sts.addr_last = addr_r == BIN_W'(BIN_COUNT - 1);
    sts.log_done  = log_done;
    sts.div_done  = ddone_r;
    sts.out_free  = !ov_r || !out_stall;
  end

  assign out_valid         = ov_r;
  assign out_entropy_value = ent_r;
  assign out_is_high       = high_r;
  assign out_run_length    = run_r;

endmodule

`default_nettype wire

// File: design/bem_ctrl.sv
// ----------------------------------------------------------------------------
// bem_ctrl
// Sequencer: clearing sweep, per-byte histogram update, end-of-run walk,
// log2(N), divide and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bem_ctrl
  import bem_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_WR   = 4'd3;
  localparam logic [3:0] S_WRD  = 4'd4;
  localparam logic [3:0] S_WCHK = 4'd5;
  localparam logic [3:0] S_WLOG = 4'd6;
  localparam logic [3:0] S_WACC = 4'd7;
  localparam logic [3:0] S_NEXT = 4'd8;
  localparam logic [3:0] S_NLOG = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_RES  = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.wr_zero  = 1'b1;
        cmd.addr_inc = 1'b1;
        if (sts.addr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_byte = 1'b1;
        state_nxt   = S_WR;
      end
      S_WR: begin
        cmd.wr_inc = 1'b1;
        state_nxt  = sts.last_flag ? S_WRD : S_IDLE;
      end
      S_WRD: begin
        cmd.rd_walk = 1'b1;
        state_nxt   = S_WCHK;
      end
      S_WCHK: begin
        cmd.wr_zero = 1'b1;
        if (sts.bin_zero) begin
          state_nxt = S_NEXT;
        end else begin
          cmd.log_start = 1'b1;
          state_nxt     = S_WLOG;
        end
      end
      S_WLOG: begin
        if (sts.log_done) begin
          cmd.prod_load = 1'b1;
          state_nxt     = S_WACC;
        end
      end
      S_WACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_NEXT;
      end
      S_NEXT: begin
        // pointer wraps to bin 0 after the last bin
        cmd.addr_inc = 1'b1;
        if (sts.addr_last) begin
          cmd.log_start = 1'b1;
          cmd.log_src_n = 1'b1;
          state_nxt     = S_NLOG;
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_NLOG: begin
        if (sts.log_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

`default_nettype wire

// File: design/byte_entropy_meter_top.sv
// ----------------------------------------------------------------------------
// byte_entropy_meter_top
// Shannon entropy of a byte run, Q4.12 bits per byte, with threshold flag.
// ----------------------------------------------------------------------------
// Input channel: one byte per beat (in_data_byte, in_last_byte), valid/stall.
// A byte goes through accept, histogram read and write back; in_stall is high
// between, so no new beat is taken before the last one is through.
// On a last byte the block walks all 256 bins, clearing each as it goes: an
// empty bin is read, checked and cleared; an occupied bin also goes through
// the log2 unit (shift-normalize, then one squaring per fraction bit), the
// multiply and the add. Then log2 of the count and a 49-step restoring
// divide. The result beat (entropy, is_high, run_length) is held in an
// output register until taken; while it waits the next run's bytes are
// accepted. A new result can only be loaded once the previous one has gone,
// so a stalled receiver eventually backs up into in_stall. After rst_n the
// histogram is cleared in a sweep over all 256 bins, with in_stall high.
// The threshold register (byte address 0, reset 7.0) is written over APB;
// the user must write it only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_entropy_meter_top
  import bem_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_last_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ENT_W-1:0]       out_entropy_value,
  output logic                   out_is_high,
  output logic [RUN_W-1:0]       out_run_length,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  ctl_cmd_t    cmd;
  ctl_sts_t    sts;
  logic [15:0] thr_r;
  logic        reg_hit;

  // word select only; byte lanes within the word are ignored
  assign reg_hit = paddr[2] == REG_THRESHOLD;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {16'h0, thr_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      thr_r <= pwdata[15:0];
    end
  end

  bem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bem_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .threshold         (thr_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_entropy_value (out_entropy_value),
    .out_is_high       (out_is_high),
    .out_run_length    (out_run_length)
  );

endmodule

`default_nettype wire

// File: design/bem_checker.sv
// ----------------------------------------------------------------------------
// bem_checker
// Port-level checks on the entropy meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bem_checker
  import bem_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [ENT_W-1:0]  out_entropy_value,
  input  wire logic              out_is_high,
  input  wire logic [RUN_W-1:0]  out_run_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable({out_entropy_value, out_is_high, out_run_length}))
    else $error("result beat changed while stalled");

  a_ent_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entropy_value <= 16'd32768)
    else $error("entropy above 8.0");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_length != '0)
    else $error("result with empty run");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("byte accepted on back-to-back cycles");

endmodule

bind byte_entropy_meter_top bem_checker u_bem_checker (.*);

`default_nettype wire
